// ===== rtl/qke_pkg.sv =====
// Shared types, codes and the per-knob timer step of the quadrature knob emulator.
package qke_pkg;

  localparam logic [15:0] PeriodReset = 16'd400;
  localparam logic [15:0] LagReset    = 16'd600;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2
  } req_e;

  typedef enum logic {
    CFG_PERIOD = 1'b0,
    CFG_LAG    = 1'b1
  } cfg_e;

  typedef struct packed {
    logic        lvl_a;
    logic        lvl_b;
    logic [16:0] lead_el;
    logic [16:0] lag_el;
    logic [16:0] off_el;
    logic        lead_run;
    logic        lag_run;
    logic        off_run;
    logic [7:0]  edges_done;
    logic [7:0]  edges_target;
    logic        turn_down;
    logic        busy;
  } knob_t;

  // one tick of a busy knob: leading timer, then lag, then lagging timer
  function automatic knob_t knob_tick(knob_t s, logic [15:0] per, logic [15:0] lag);
    knob_t       n;
    logic [16:0] e;
    logic        lead_lvl;
    logic        off_fired;
    n = s;
    off_fired = 1'b0;
    if (n.lead_run) begin
      e = n.lead_el + 17'd1;
      if (e > {1'b0, per}) begin
        e = e - {1'b0, per};
        if (n.turn_down) begin
          n.lvl_b = ~n.lvl_b;
        end else begin
          n.lvl_a = ~n.lvl_a;
        end
      end
      n.lead_el = e;
    end
    lead_lvl = n.turn_down ? n.lvl_b : n.lvl_a;
    if (n.off_run) begin
      e = n.off_el + 17'd1;
      n.off_el = e;
      if (e > {1'b0, lag}) begin
        n.off_run = 1'b0;
        if (n.turn_down) begin
          n.lvl_a = lead_lvl;
        end else begin
          n.lvl_b = lead_lvl;
        end
        n.edges_done = n.edges_done + 8'd1;
        n.lag_run = 1'b1;
        n.lag_el = '0;
        off_fired = 1'b1;
      end
    end
    if (!off_fired && n.lag_run) begin
      e = n.lag_el + 17'd1;
      if (e > {1'b0, per}) begin
        e = e - {1'b0, per};
        if (n.turn_down) begin
          n.lvl_a = ~n.lvl_a;
        end else begin
          n.lvl_b = ~n.lvl_b;
        end
        n.edges_done = n.edges_done + 8'd1;
      end
      n.lag_el = e;
    end
    return n;
  endfunction

endpackage

// ===== rtl/qke_intf.sv =====
// Request, response and configuration channel interfaces of the knob emulator.
interface qke_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       knob_index;
  logic [7:0] edge_count;
  modport source (output valid, req_type, knob_index, edge_count, input ready);
  modport sink (input valid, req_type, knob_index, edge_count, output ready);
endinterface

interface qke_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase_a_levels;
  logic [1:0] phase_b_levels;
  logic [1:0] done_mask;
  logic [1:0] busy_mask;
  modport source (output valid, phase_a_levels, phase_b_levels, done_mask, busy_mask,
                  input ready);
  modport sink (input valid, phase_a_levels, phase_b_levels, done_mask, busy_mask,
                output ready);
endinterface

interface qke_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/qke_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qke_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/quadrature_knob_emulator_core.sv =====
// Top level of the quadrature knob emulator: state row RAM, update stage, response register.
//
//  channel | dir | handshake     | payload
//  req_i   | in  | valid/ready   | req_type, knob_index, edge_count
//  rsp_o   | out | valid/ready   | phase_a/b_levels, done_mask, busy_mask
//  cfg_i   | in  | valid/ready=1 | index (0 period, 1 lag), data
//
// One request per cycle unless rsp_o stalls; update stage, then response register.
// All knob state sits in one RAM row read on accept and written back by the update
// stage; a request accepted while the previous one writes takes the forwarded row.
// After reset the row reads as all zero until first written; no clearing pass.
// A stalled response holds the update stage; the stage then holds its request.
module quadrature_knob_emulator_core import qke_pkg::*; #(
  parameter int NumKnobs = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  qke_req_if.sink   req_i,
  qke_rsp_if.source rsp_o,
  qke_cfg_if.sink   cfg_i
);

  typedef knob_t [NumKnobs-1:0] row_t;
  localparam int RowW = $bits(row_t);

  logic [15:0] period_q, lag_q;
  logic        s1_valid_q;
  logic [1:0]  s1_req_q;
  logic        s1_idx_q;
  logic [7:0]  s1_cnt_q;
  logic        use_fwd_q, use_zero_q, mem_init_q;
  row_t        fwd_q;
  logic        out_valid_q;
  logic [1:0]  out_a_q, out_b_q, out_done_q, out_busy_q;

  logic            req_fire, s1_fire, out_free;
  logic [RowW-1:0] ram_rdata;
  row_t            cur, nxt;
  logic [NumKnobs-1:0] done_vec;
  logic [1:0]      a_bits, b_bits, d_bits, busy_bits;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || s1_fire;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  qke_ram #(
    .WIDTH (RowW),
    .DEPTH (1)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (1'b0),
    .wdata_i (nxt),
    .re_i    (req_fire),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (use_fwd_q) begin
      cur = fwd_q;
    end else if (use_zero_q) begin
      cur = '0;
    end else begin
      cur = row_t'(ram_rdata);
    end
  end

  always_comb begin
    logic touched;
    nxt = cur;
    done_vec = '0;
    for (int k = 0; k < NumKnobs; k++) begin
      touched = 1'b0;
      unique case (s1_req_q) inside
        REQ_TICK: begin
          if (cur[k].busy) begin
            nxt[k] = knob_tick(cur[k], period_q, lag_q);
            touched = 1'b1;
          end
        end
        REQ_UP, REQ_DOWN: begin
          if (int'(s1_idx_q) == k) begin
            nxt[k].turn_down    = (s1_req_q == REQ_DOWN);
            nxt[k].edges_target = s1_cnt_q;
            nxt[k].edges_done   = '0;
            nxt[k].busy         = 1'b1;
            nxt[k].lead_run     = 1'b1;
            nxt[k].lead_el      = '0;
            nxt[k].lag_run      = 1'b0;
            nxt[k].lag_el       = '0;
            nxt[k].off_run      = 1'b1;
            nxt[k].off_el       = '0;
            touched = 1'b1;
          end
        end
        default: ;
      endcase
      if (touched && nxt[k].busy && nxt[k].edges_done == nxt[k].edges_target) begin
        nxt[k].busy     = 1'b0;
        nxt[k].lead_run = 1'b0;
        nxt[k].lag_run  = 1'b0;
        nxt[k].off_run  = 1'b0;
        done_vec[k]     = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_out
    if (g < NumKnobs) begin : g_on
      assign a_bits[g]    = nxt[g].lvl_a;
      assign b_bits[g]    = nxt[g].lvl_b;
      assign d_bits[g]    = done_vec[g];
      assign busy_bits[g] = nxt[g].busy;
    end else begin : g_off
      assign a_bits[g]    = 1'b0;
      assign b_bits[g]    = 1'b0;
      assign d_bits[g]    = 1'b0;
      assign busy_bits[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      lag_q       <= LagReset;
      s1_valid_q  <= 1'b0;
      use_fwd_q   <= 1'b0;
      use_zero_q  <= 1'b0;
      mem_init_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_PERIOD: period_q <= cfg_i.data;
          CFG_LAG:    lag_q    <= cfg_i.data;
          default: ;
        endcase
      end
      if (req_fire) begin
        s1_valid_q <= 1'b1;
        use_fwd_q  <= s1_fire;
        use_zero_q <= !mem_init_q && !s1_fire;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        mem_init_q  <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_req_q <= req_i.req_type;
      s1_idx_q <= req_i.knob_index;
      s1_cnt_q <= req_i.edge_count;
    end
    if (s1_fire) begin
      fwd_q      <= nxt;
      out_a_q    <= a_bits;
      out_b_q    <= b_bits;
      out_done_q <= d_bits;
      out_busy_q <= busy_bits;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.phase_a_levels = out_a_q;
  assign rsp_o.phase_b_levels = out_b_q;
  assign rsp_o.done_mask      = out_done_q;
  assign rsp_o.busy_mask      = out_busy_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_done_q & out_busy_q) == 2'b00))
    else $error("knob reported done while still busy");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_fwd_q |-> mem_init_q)
    else $error("forwarded row used before any write");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("update stage result lost");

  a_fwd_not_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(use_fwd_q && use_zero_q))
    else $error("conflicting row sources");

endmodule
